FILE: hdl/jct_pkg.sv
// Shared types and constants of the job completion tracker.
`default_nettype none

package jct_pkg;

  localparam int unsigned JobW       = 31;
  localparam int unsigned PortW      = 16;
  localparam int unsigned NumPorts   = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] DoneMax = 2'd3;

  typedef enum logic [1:0] {
    KIND_DEPLOY = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_FETCH  = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_DEPLOY   = 3'd0,
    OP_BAD_REPS = 3'd1,
    OP_STATUS   = 3'd2,
    OP_FETCH    = 3'd3,
    OP_DONE     = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    STAT_DEPLOYED   = 3'd0,
    STAT_COMPLETED  = 3'd1,
    STAT_RUNNING    = 3'd2,
    STAT_NOT_FOUND  = 3'd3,
    STAT_TABLE_FULL = 3'd4,
    STAT_BAD_REPS   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_PORT_ZERO = 2'd0,
    CFG_PORT_ONE  = 2'd1,
    CFG_PORT_TWO  = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_REPLY = 2'd2
  } eng_state_e;

  typedef logic [PortW-1:0] port_t;
  typedef port_t [NumPorts-1:0] port_set_t;

  typedef struct packed {
    op_e             op;
    logic [1:0]      reps;
    logic [JobW-1:0] job;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic [JobW-1:0] job;
    logic [1:0]      count;
    port_set_t       ports;
  } result_t;

  typedef struct packed {
    logic [JobW-1:0] job;
    logic [1:0]      needed;
    logic [1:0]      done;
    port_set_t       ports;
  } slot_row_t;

endpackage

`default_nettype wire

FILE: hdl/jct_fifo.sv
// Small register-based queue used between the tracker stages.
`default_nettype none

module jct_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/jct_front.sv
// Front end: accepts requests, classifies them and queues them for the engine.
`default_nettype none

module jct_front #(
  parameter int unsigned WORKERS = 3
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [1:0]                  replicas_i,
  input  wire logic [jct_pkg::JobW-1:0]    job_ref_i,
  output logic                             full_o,
  input  wire logic                        req_pop_i,
  output logic                             req_valid_o,
  output jct_pkg::req_t                    req_o
);

  import jct_pkg::*;

  req_t                    req_in;
  logic [$bits(req_t)-1:0] q_data;
  logic                    q_empty;

  // A deploy with a replica count outside one to WORKERS is marked here so
  // that the engine answers it without touching the table.
  always_comb begin
    req_in.reps = replicas_i;
    req_in.job  = job_ref_i;
    req_in.op   = OP_DEPLOY;
    unique case (kind_i)
      KIND_DEPLOY: begin
        if (replicas_i == 2'd0 || replicas_i > 2'(WORKERS)) begin
          req_in.op = OP_BAD_REPS;
        end else begin
          req_in.op = OP_DEPLOY;
        end
      end
      KIND_STATUS: req_in.op = OP_STATUS;
      KIND_FETCH:  req_in.op = OP_FETCH;
      KIND_DONE:   req_in.op = OP_DONE;
      default:     req_in.op = OP_DEPLOY;
    endcase
  end

  jct_fifo #(
    .Width ($bits(req_t)),
    .Depth (QueueDepth)
  ) u_req_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (req_in),
    .full_o  (full_o),
    .pop_i   (req_pop_i),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  assign req_valid_o = !q_empty;
  assign req_o       = req_t'(q_data);

endmodule

`default_nettype wire

FILE: hdl/jct_back.sv
// Back end: scans the job table and carries out one request at a time.
`default_nettype none

module jct_back #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned WORKERS     = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  input  wire jct_pkg::req_t       req_i,
  output logic                     req_pop_o,
  input  wire jct_pkg::port_set_t  worker_ports_i,
  input  wire logic                res_full_i,
  output logic                     res_push_o,
  output jct_pkg::result_t         res_o
);

  import jct_pkg::*;

  localparam int unsigned SlotW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH + 1);

  eng_state_e             state_q, state_d;
  req_t                   req_q, req_d;
  result_t                res_q, res_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic [SlotW-1:0]       cmp_idx_q, cmp_idx_d;
  logic [1:0]             rr_q, rr_d;
  logic [JobW-1:0]        next_job_q, next_job_d;
  logic [TABLE_DEPTH-1:0] used_q;

  slot_row_t              mem_q [TABLE_DEPTH];
  slot_row_t              rd_q;
  slot_row_t              wr_row;
  logic [SlotW-1:0]       wr_addr;
  logic                   wr_en, rd_en;
  logic                   used_we, used_wval;

  logic [SlotW-1:0]       idx_slot;
  logic                   issue_left, is_deploy, slot_free, at_last;
  logic                   hit, last_cmp, scan_done, job_complete;
  port_set_t              new_ports;
  logic [1:0]             rr_ptr;

  assign idx_slot     = idx_q[SlotW-1:0];
  assign issue_left   = (idx_q < IdxW'(TABLE_DEPTH));
  assign is_deploy    = (req_q.op == OP_DEPLOY);
  assign slot_free    = !used_q[idx_slot];
  assign at_last      = (idx_slot == SlotW'(TABLE_DEPTH - 1));
  assign hit          = cmp_vld_q && used_q[cmp_idx_q] && (rd_q.job == req_q.job);
  assign last_cmp     = cmp_vld_q && (cmp_idx_q == SlotW'(TABLE_DEPTH - 1));
  assign job_complete = (rd_q.done == rd_q.needed);
  assign scan_done    = is_deploy ? (slot_free || at_last) : (hit || last_cmp);

  // Round-robin hand-out of worker ports for a deploy.
  always_comb begin
    rr_ptr = rr_q;
    for (int k = 0; k < NumPorts; k++) begin
      if (2'(k) < req_q.reps) begin
        new_ports[k] = worker_ports_i[rr_ptr];
        rr_ptr = (rr_ptr == 2'(WORKERS - 1)) ? 2'd0 : rr_ptr + 2'd1;
      end else begin
        new_ports[k] = '0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = (req_i.op == OP_BAD_REPS) ? ST_REPLY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = (req_q.op == OP_DONE) ? ST_IDLE : ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (!res_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_pop_o  = 1'b0;
    res_push_o = 1'b0;
    req_d      = req_q;
    res_d      = res_q;
    idx_d      = idx_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    rr_d       = rr_q;
    next_job_d = next_job_q;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = cmp_idx_q;
    wr_row     = rd_q;
    used_we    = 1'b0;
    used_wval  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_pop_o = req_valid_i;
        if (req_valid_i) begin
          req_d        = req_i;
          idx_d        = '0;
          res_d.status = STAT_BAD_REPS;
          res_d.job    = '0;
          res_d.count  = '0;
          res_d.ports  = '0;
        end
      end
      ST_SCAN: begin
        res_d.job   = req_q.job;
        res_d.count = '0;
        res_d.ports = '0;
        if (is_deploy) begin
          if (slot_free) begin
            wr_en         = 1'b1;
            wr_addr       = idx_slot;
            wr_row.job    = next_job_q;
            wr_row.needed = req_q.reps;
            wr_row.done   = '0;
            wr_row.ports  = new_ports;
            used_we       = 1'b1;
            used_wval     = 1'b1;
            rr_d          = rr_ptr;
            next_job_d    = next_job_q + JobW'(1);
            res_d.status  = STAT_DEPLOYED;
            res_d.job     = next_job_q;
            res_d.count   = req_q.reps;
            res_d.ports   = new_ports;
          end else if (at_last) begin
            res_d.status = STAT_TABLE_FULL;
            res_d.job    = '0;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end else if (hit) begin
          res_d.status = job_complete ? STAT_COMPLETED : STAT_RUNNING;
          case (req_q.op)
            OP_DONE: begin
              if (rd_q.done != DoneMax) begin
                wr_en       = 1'b1;
                wr_row.done = rd_q.done + 2'd1;
              end
            end
            OP_FETCH: begin
              if (job_complete) begin
                res_d.count = rd_q.needed;
                res_d.ports = rd_q.ports;
                used_we     = 1'b1;
                used_wval   = 1'b0;
              end
            end
            default: ;
          endcase
        end else if (last_cmp) begin
          res_d.status = STAT_NOT_FOUND;
        end else if (issue_left) begin
          rd_en     = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_slot;
          idx_d     = idx_q + IdxW'(1);
        end
      end
      ST_REPLY: begin
        res_push_o = !res_full_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      rr_q       <= '0;
      next_job_q <= '0;
      used_q     <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      cmp_vld_q  <= cmp_vld_d;
      cmp_idx_q  <= cmp_idx_d;
      rr_q       <= rr_d;
      next_job_q <= next_job_d;
      if (used_we) begin
        used_q[wr_addr] <= used_wval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  // Slot table: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_q <= mem_q[idx_slot];
    end
  end

  assign res_o = res_q;

  a_rr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rr_q < 2'(WORKERS))
    else $error("round-robin pointer past the last worker");

  a_alloc_sets_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_we && used_wval) |=> used_q[$past(wr_addr)])
    else $error("allocated slot not marked used");

  a_job_counter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_job_q == $past(next_job_q)) || (next_job_q == $past(next_job_q) + JobW'(1)))
    else $error("job counter moved by more than one");

  a_no_compare_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !cmp_vld_q)
    else $error("table compare pending while idle");

endmodule

`default_nettype wire

FILE: hdl/job_completion_tracker_core.sv
// Top level of the job completion tracker: configuration, front end, engine, result queue.
//
// Usage. Requests enter through a queue-like port: a request is taken at a
// rising edge where push is high and full is low. Each request carries kind_i
// (deploy, status, results fetch, worker completion), replicas_i and job_ref_i.
// Results leave through a second queue-like port: while empty is low the oldest
// result sits on status_code_o, job_number_o, port_count_o and port_a/b/c_o,
// and it is taken at an edge where pop is high. Worker completions give no result.
// The three worker service ports are written over the cfg channel (valid/ready,
// always ready); an index of three is ignored. Write them only while idle.
// Flow: a request waits in a two-entry front queue, then the engine takes it,
// scans the slot table one entry per cycle and hands the result to the
// two-entry result queue. The engine carries out one request at a time, so
// the scan of the slot table sets the throughput. Reset empties the table
// and both queues, zeroes the worker ports, the round-robin pointer and the
// job counter. If the receiver stops popping, the result queue fills, the
// engine holds its answer, and full rises once the front queue is full as
// well; nothing is dropped.
`default_nettype none

module job_completion_tracker_core #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned WORKERS     = 3
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [1:0]               kind_i,
  input  wire logic [1:0]               replicas_i,
  input  wire logic [jct_pkg::JobW-1:0] job_ref_i,
  input  wire logic                     pop,
  output logic                          empty,
  output logic [2:0]                    status_code_o,
  output logic [jct_pkg::JobW-1:0]      job_number_o,
  output logic [1:0]                    port_count_o,
  output logic [jct_pkg::PortW-1:0]     port_a_o,
  output logic [jct_pkg::PortW-1:0]     port_b_o,
  output logic [jct_pkg::PortW-1:0]     port_c_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [1:0]               cfg_index_i,
  input  wire logic [jct_pkg::PortW-1:0] cfg_data_i
);

  import jct_pkg::*;

  port_set_t                  worker_port_q;
  req_t                       req;
  logic                       req_valid, req_pop;
  result_t                    res_in, res_out;
  logic                       res_push, res_full;
  logic [$bits(result_t)-1:0] res_q_data;

  // The configuration channel never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worker_port_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PORT_ZERO: worker_port_q[0] <= cfg_data_i;
        CFG_PORT_ONE:  worker_port_q[1] <= cfg_data_i;
        CFG_PORT_TWO:  worker_port_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: request queue and classification of each request.
  jct_front #(
    .WORKERS (WORKERS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .kind_i      (kind_i),
    .replicas_i  (replicas_i),
    .job_ref_i   (job_ref_i),
    .full_o      (full),
    .req_pop_i   (req_pop),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  // Engine: walks the slot table and updates it.
  jct_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WORKERS     (WORKERS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid),
    .req_i          (req),
    .req_pop_o      (req_pop),
    .worker_ports_i (worker_port_q),
    .res_full_i     (res_full),
    .res_push_o     (res_push),
    .res_o          (res_in)
  );

  // Result queue decouples the engine from a stalled receiver.
  jct_fifo #(
    .Width ($bits(result_t)),
    .Depth (QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_q_data),
    .empty_o (empty)
  );

  assign res_out       = result_t'(res_q_data);
  assign status_code_o = res_out.status;
  assign job_number_o  = res_out.job;
  assign port_count_o  = res_out.count;
  assign port_a_o      = res_out.ports[0];
  assign port_b_o      = res_out.ports[1];
  assign port_c_o      = res_out.ports[2];

endmodule

`default_nettype wire
